FILE: rtl/sha1sh_pkg.sv
// Shared types and constants for the SHA-1 stream hasher.
`default_nettype none

package sha1sh_pkg;

  localparam int unsigned NUM_CHAIN = 5;
  localparam int unsigned NUM_WORDS = 16;

  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;

  localparam logic [31:0] H_INIT [NUM_CHAIN] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [5:0] BYTE_LAST     = 6'd63;
  localparam logic [5:0] LEN_FIRST     = 6'd56;
  localparam logic [6:0] ROUND_LAST    = 7'd79;
  localparam logic [6:0] ROUND_PHASE1  = 7'd20;
  localparam logic [6:0] ROUND_PHASE2  = 7'd40;
  localparam logic [6:0] ROUND_PHASE3  = 7'd60;
  localparam logic [2:0] IDX_LAST      = 3'd4;
  localparam logic [7:0] PAD_MARK      = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_ZERO,
    S_LEN,
    S_ROUND,
    S_ADD,
    S_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_e;

  typedef struct packed {
    logic      put;
    byte_src_e src;
    logic      count_bits;
    logic      round;
    logic      chain_add;
    logic      emit;
    logic      restart;
  } dp_cmd_t;

  typedef struct packed {
    logic blk_last;
    logic at_len;
    logic round_last;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/sha1sh_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
`default_nettype none

interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha1sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

FILE: rtl/sha1_stream_hasher.sv
// Top level of the streaming SHA-1 hasher: controller, datapath and channel hookup.
// Intake: a byte that does not fill the block is taken without a stall; the 64th byte of a
//   block starts a compression of 80 rounds on one shared round unit and a chain add.
// End of message: padding bytes plus one or two compressions, then
//   five digest words, one per cycle while the sink is ready.
// Reset: asynchronous, active low; chain words return to the SHA-1 initial values.
`default_nettype none

module sha1_stream_hasher import sha1sh_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sha1sh_in_if.sink     msg_i,
  sha1sh_out_if.source  dig_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha1sh_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (msg_i.valid),
    .byte_valid_i     (msg_i.byte_valid),
    .end_of_message_i (msg_i.end_of_message),
    .stat_i           (stat),
    .in_ready_o       (msg_i.ready),
    .cmd_o            (cmd)
  );

  sha1sh_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (msg_i.data_byte),
    .out_ready_i   (dig_o.ready),
    .stat_o        (stat),
    .out_valid_o   (dig_o.valid),
    .digest_word_o (dig_o.digest_word),
    .word_index_o  (dig_o.word_index),
    .last_word_o   (dig_o.last_word)
  );

  a_round_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round |-> !msg_i.ready)
    else $error("input accepted during compression");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.put, cmd.round, cmd.chain_add, cmd.emit}))
    else $error("conflicting datapath commands");

  a_last_word_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_o.valid |-> (dig_o.last_word == (dig_o.word_index == IDX_LAST)))
    else $error("last_word does not match word_index");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.restart |-> cmd.emit && stat.emit_last)
    else $error("restart outside final digest word");

endmodule

`default_nettype wire

FILE: rtl/sha1sh_dp.sv
// SHA-1 datapath: block buffer, message schedule, round unit, chain and output register.
`default_nettype none

module sha1sh_dp import sha1sh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        out_ready_i,
  output dp_stat_t         stat_o,
  output logic             out_valid_o,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  logic [5:0]  cnt_q;
  logic [6:0]  rnd_q;
  logic [63:0] bits_q;
  logic [31:0] chain_q [NUM_CHAIN];
  logic [2:0]  emit_idx_q;
  logic        out_valid_q;

  logic [31:0] blk_q [NUM_WORDS];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_idx_q;
  logic        out_last_q;

  logic [7:0]  byte_val;
  logic [31:0] f_val, k_val, t_val, w_new;
  logic        out_free;

  function automatic logic [31:0] w_mix(input logic [31:0] w13, input logic [31:0] w8,
                                        input logic [31:0] w2, input logic [31:0] w0);
    logic [31:0] x;
    x = w13 ^ w8 ^ w2 ^ w0;
    return {x[30:0], x[31]};
  endfunction

  always_comb begin
    case (cmd_i.src)
      SRC_DATA: byte_val = data_byte_i;
      SRC_MARK: byte_val = PAD_MARK;
      SRC_ZERO: byte_val = 8'h00;
      SRC_LEN:  byte_val = bits_q[{~cnt_q[2:0], 3'b000} +: 8];
      default:  byte_val = 8'h00;
    endcase
  end

  always_comb begin
    if (rnd_q < ROUND_PHASE1) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = K_R0;
    end else if (rnd_q < ROUND_PHASE2) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_R1;
    end else if (rnd_q < ROUND_PHASE3) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = K_R2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_R3;
    end
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + blk_q[0];
  assign w_new = {w_mix(blk_q[13], blk_q[8], blk_q[2], blk_q[0])};

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rnd_q       <= '0;
      bits_q      <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHAIN; i++) chain_q[i] <= H_INIT[i];
    end else begin
      if (cmd_i.put) cnt_q <= cnt_q + 6'd1;
      if (cmd_i.count_bits) bits_q <= bits_q + 64'd8;
      if (cmd_i.put && stat_o.blk_last) begin
        rnd_q <= '0;
      end else if (cmd_i.round) begin
        rnd_q <= rnd_q + 7'd1;
      end
      if (cmd_i.chain_add) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end
      if (cmd_i.emit) begin
        emit_idx_q  <= emit_idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.restart) begin
        cnt_q      <= '0;
        bits_q     <= '0;
        emit_idx_q <= '0;
        for (int i = 0; i < NUM_CHAIN; i++) chain_q[i] <= H_INIT[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      blk_q[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] <= byte_val;
    end else if (cmd_i.round) begin
      for (int i = 0; i < NUM_WORDS - 1; i++) blk_q[i] <= blk_q[i + 1];
      blk_q[NUM_WORDS - 1] <= w_new;
    end
    if (cmd_i.put && stat_o.blk_last) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (cmd_i.round) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
    if (cmd_i.emit) begin
      out_word_q <= chain_q[emit_idx_q];
      out_idx_q  <= emit_idx_q;
      out_last_q <= (emit_idx_q == IDX_LAST);
    end
  end

  always_comb begin
    stat_o.blk_last   = (cnt_q == BYTE_LAST);
    stat_o.at_len     = (cnt_q == LEN_FIRST);
    stat_o.round_last = (rnd_q == ROUND_LAST);
    stat_o.emit_last  = (emit_idx_q == IDX_LAST);
    stat_o.out_free   = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/sha1sh_ctrl.sv
// SHA-1 controller: byte intake, padding sequence, compression rounds and digest output.
`default_nettype none

module sha1sh_ctrl import sha1sh_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     byte_valid_i,
  input  wire logic     end_of_message_i,
  input  wire dp_stat_t stat_i,
  output logic          in_ready_o,
  output dp_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  ctrl_state_e ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (byte_valid_i && stat_i.blk_last) begin
            state_d = S_ROUND;
            ret_d   = end_of_message_i ? S_MARK : S_IDLE;
          end else if (end_of_message_i) begin
            state_d = S_MARK;
          end
        end
      end
      S_MARK: begin
        if (stat_i.blk_last) begin
          state_d = S_ROUND;
          ret_d   = S_ZERO;
        end else begin
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        if (stat_i.at_len) begin
          state_d = S_LEN;
        end else if (stat_i.blk_last) begin
          state_d = S_ROUND;
          ret_d   = S_ZERO;
        end
      end
      S_LEN: begin
        if (stat_i.blk_last) begin
          state_d = S_ROUND;
          ret_d   = S_EMIT;
        end
      end
      S_ROUND: begin
        if (stat_i.round_last) state_d = S_ADD;
      end
      S_ADD: state_d = ret_q;
      S_EMIT: begin
        if (stat_i.out_free && stat_i.emit_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.src  = SRC_DATA;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && byte_valid_i) begin
          cmd_o.put        = 1'b1;
          cmd_o.count_bits = 1'b1;
        end
      end
      S_MARK: begin
        cmd_o.put = 1'b1;
        cmd_o.src = SRC_MARK;
      end
      S_ZERO: begin
        cmd_o.put = !stat_i.at_len;
        cmd_o.src = SRC_ZERO;
      end
      S_LEN: begin
        cmd_o.put = 1'b1;
        cmd_o.src = SRC_LEN;
      end
      S_ROUND: cmd_o.round = 1'b1;
      S_ADD:   cmd_o.chain_add = 1'b1;
      S_EMIT: begin
        cmd_o.emit    = stat_i.out_free;
        cmd_o.restart = stat_i.out_free && stat_i.emit_last;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: dv/sha1_digest_checker.sv
// Checker for the SHA-1 stream hasher: predicts digests from accepted bytes and compares.
module sha1_digest_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  sha1sh_in_if  msg_i,
  sha1sh_out_if dig_i,
  output int    fail_count_o,
  output int    pending_o
);

  localparam logic [31:0] ROUND_K [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };
  localparam logic [31:0] CHAIN_IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam logic [6:0] FILL_FULL   = 7'd64;
  localparam logic [6:0] FILL_LEN_AT = 7'd56;
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam int         DIGEST_LEN  = 5;
  localparam int         REPORT_MAX  = 10;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0]  chain_q [5];
  logic [31:0]  blk_q [16];
  logic [6:0]   fill_q;
  logic [63:0]  bits_q;
  digest_word_t expected_digest_q [$];

  function automatic logic [31:0] rol32(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void clear_state();
    for (int i = 0; i < 5; i++) chain_q[i] = CHAIN_IV[i];
    for (int i = 0; i < 16; i++) blk_q[i] = '0;
    fill_q = '0;
    bits_q = '0;
  endfunction

  // Packs one byte big-endian; a full block is compressed into the chain.
  function automatic void load_byte(logic [7:0] b_in);
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int unsigned s;
    blk_q[fill_q[5:2]][31 - 8 * fill_q[1:0] -: 8] = b_in;
    fill_q = fill_q + 7'd1;
    if (fill_q == FILL_FULL) begin
      w = blk_q;
      a = chain_q[0];
      b = chain_q[1];
      c = chain_q[2];
      d = chain_q[3];
      e = chain_q[4];
      for (int r = 0; r < 80; r++) begin
        s = r % 16;
        if (r >= 16) begin
          w[s] = rol32(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
        end else if (r >= 40 && r < 60) begin
          f = (b & c) | (b & d) | (c & d);
        end else begin
          f = b ^ c ^ d;
        end
        k = ROUND_K[r / 20];
        t = rol32(a, 5) + f + e + k + w[s];
        e = d;
        d = c;
        c = rol32(b, 30);
        b = a;
        a = t;
      end
      chain_q[0] += a;
      chain_q[1] += b;
      chain_q[2] += c;
      chain_q[3] += d;
      chain_q[4] += e;
      fill_q = '0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_check
    logic [63:0]  msg_len;
    digest_word_t got;
    digest_word_t want;
    if (!rst_ni) begin
      clear_state();
      expected_digest_q.delete();
      fail_count_o = 0;
    end else begin
      if (msg_i.valid && msg_i.ready) begin
        if (msg_i.byte_valid) begin
          load_byte(msg_i.data_byte);
          bits_q = bits_q + 64'd8;
        end
        if (msg_i.end_of_message) begin
          msg_len = bits_q;
          load_byte(PAD_BYTE);
          while (fill_q != FILL_LEN_AT) load_byte(8'h00);
          for (int i = 7; i >= 0; i--) load_byte(msg_len[8 * i +: 8]);
          for (int i = 0; i < DIGEST_LEN; i++) begin
            want.word = chain_q[i];
            want.idx  = 3'(i);
            want.last = (i == DIGEST_LEN - 1);
            expected_digest_q.push_back(want);
          end
          clear_state();
        end
      end
      if (dig_i.valid && dig_i.ready) begin
        got = '{dig_i.digest_word, dig_i.word_index, dig_i.last_word};
        if (expected_digest_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_MAX) begin
            $display("%0t: digest word %h index %0d last %b arrived with none pending",
                     $time, got.word, got.idx, got.last);
          end
        end else begin
          want = expected_digest_q.pop_front();
          if (got.word !== want.word || got.idx !== want.idx || got.last !== want.last) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_MAX) begin
              $display("%0t: digest word expected %h/%0d/%b, got %h/%0d/%b", $time,
                       want.word, want.idx, want.last, got.word, got.idx, got.last);
            end
          end
        end
      end
    end
    pending_o = expected_digest_q.size();
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the SHA-1 stream hasher: message stimulus, digest back-pressure, verdict.
module tb_top;

  localparam int CLK_HALF       = 5;
  localparam int CLK_PERIOD     = 2 * CLK_HALF;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_ITEMS   = 218;
  localparam int IDLE_PCT       = 34;
  localparam int QUIET_FIRST    = 120;
  localparam int QUIET_LEN      = 80;
  localparam int HOLD_AT        = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int CALM_CYCLES    = 800;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       closes;
  } msg_item_t;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      hold_go = 1'b0;
  int        fail_count;
  int        pending;
  msg_item_t item_q [$];

  sha1sh_in_if  msg_if ();
  sha1sh_out_if dig_if ();

  sha1_stream_hasher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .dig_o  (dig_if)
  );

  sha1_digest_checker digest_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .msg_i        (msg_if),
    .dig_i        (dig_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic void add_item(logic [7:0] d, logic hb, logic cl);
    item_q.push_back('{d, hb, cl});
  endfunction

  initial begin : msg_source
    int sel;
    int len;
    int counted;
    int sender_idle;
    int drain_cycles;
    bit tail;
    msg_if.valid          <= 1'b0;
    msg_if.data_byte      <= 8'h00;
    msg_if.byte_valid     <= 1'b0;
    msg_if.end_of_message <= 1'b0;

    // directed: ignored item, empty message, "abc", extreme bytes, end with/without byte
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'h63, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 1'b0);
    add_item(8'hff, 1'b0, 1'b1);
    add_item(8'hff, 1'b1, 1'b1);
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'h7f, 1'b0, 1'b0);
    add_item(8'h01, 1'b1, 1'b1);

    // random messages, lengths biased toward the padding boundaries
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        len = $urandom_range(3);
      end else if (sel < 80) begin
        len = $urandom_range(65, 53);
      end else begin
        len = $urandom_range(129, 1);
      end
      if (len > RANDOM_ITEMS - counted) len = RANDOM_ITEMS - counted;
      tail = (len > 0) && ($urandom_range(1) == 1);
      for (int b = 0; b < len; b++) begin
        if ($urandom_range(9) == 0) begin
          add_item(8'($urandom), 1'b0, 1'b0);
          counted++;
        end
        add_item(8'($urandom), 1'b1, tail && (b == len - 1));
      end
      if (!tail) add_item(8'($urandom), 1'b0, 1'b1);
      counted += len + (tail ? 0 : 1);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < item_q.size(); i++) begin
      sender_idle = (i >= QUIET_FIRST && i < QUIET_FIRST + QUIET_LEN) ? 0 : IDLE_PCT;
      while ($urandom_range(99) < sender_idle) begin
        msg_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      msg_if.valid          <= 1'b1;
      msg_if.data_byte      <= item_q[i].data;
      msg_if.byte_valid     <= item_q[i].has_byte;
      msg_if.end_of_message <= item_q[i].closes;
      if (i == HOLD_AT) hold_go <= 1'b1;
      @(posedge clk_i);
      while (!msg_if.ready) @(posedge clk_i);
    end
    msg_if.valid <= 1'b0;

    drain_cycles = 0;
    while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // digest side: random stalls, one long hold-off, then a stretch always ready
  initial begin : digest_sink
    int held;
    int calm;
    held = 0;
    calm = 0;
    dig_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && held < HOLD_CYCLES) begin
        held++;
        dig_if.ready <= 1'b0;
      end else if (held == HOLD_CYCLES && calm < CALM_CYCLES) begin
        calm++;
        dig_if.ready <= 1'b1;
      end else begin
        dig_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
